// ----- rtl/spk_pkg.sv -----
// Shared types, constants and word functions for the Speck48/96 cipher pipeline.
`timescale 1ns / 1ps
`default_nettype none
package spk_pkg;

	localparam int WordW  = 24;
	localparam int Rounds = 23;
	localparam int Stages = 2 * Rounds;

	localparam logic CmdEncrypt = 1'b0;
	localparam logic CmdDecrypt = 1'b1;

	typedef logic [WordW-1:0] word_t;

	// everything a cell hands to its neighbour
	typedef struct packed {
		logic  cmd;
		word_t x;
		word_t y;
		word_t l0;
		word_t l1;
		word_t l2;
		word_t rk;
	} stage_t;

	function automatic word_t rotl(input word_t v, input int s);
		rotl = (v << s) | (v >> (WordW - s));
	endfunction

endpackage
`default_nettype wire

// ----- rtl/spk_fwd_cell.sv -----
// Forward cell: one encrypt round and one key schedule step.
`timescale 1ns / 1ps
`default_nettype none
module spk_fwd_cell #(
	parameter int IDX = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  up_valid,
	input  wire spk_pkg::stage_t up_data,
	output logic                 up_ready,
	output logic                 dn_valid,
	output spk_pkg::stage_t      dn_data,
	input  wire                  dn_ready
);

	spk_pkg::stage_t nxt;
	spk_pkg::word_t  nl;
	logic            valid_q;
	spk_pkg::stage_t data_q;

	always_comb begin
		nxt = up_data;
		if (up_data.cmd == spk_pkg::CmdEncrypt) begin
			nxt.x = (spk_pkg::rotl(up_data.x, 16) + up_data.y) ^ up_data.rk;
			nxt.y = spk_pkg::rotl(up_data.y, 3) ^ nxt.x;
		end
		nl = (spk_pkg::rotl(up_data.l0, 16) + up_data.rk) ^ spk_pkg::word_t'(IDX);
		// last cell holds the final round key for the decrypt half
		if (IDX < spk_pkg::Rounds - 1) begin
			nxt.rk = spk_pkg::rotl(up_data.rk, 3) ^ nl;
			nxt.l0 = up_data.l1;
			nxt.l1 = up_data.l2;
			nxt.l2 = nl;
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule
`default_nettype wire

// ----- rtl/spk_rev_cell.sv -----
// Reverse cell: one decrypt round and one inverted key schedule step.
`timescale 1ns / 1ps
`default_nettype none
module spk_rev_cell #(
	parameter int IDX = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  up_valid,
	input  wire spk_pkg::stage_t up_data,
	output logic                 up_ready,
	output logic                 dn_valid,
	output spk_pkg::stage_t      dn_data,
	input  wire                  dn_ready
);

	spk_pkg::stage_t nxt;
	spk_pkg::word_t  prev_rk;
	logic            valid_q;
	spk_pkg::stage_t data_q;

	always_comb begin
		nxt = up_data;
		if (up_data.cmd == spk_pkg::CmdDecrypt) begin
			nxt.y = spk_pkg::rotl(up_data.y ^ up_data.x, 21);
			nxt.x = spk_pkg::rotl((up_data.x ^ up_data.rk) - nxt.y, 8);
		end
		// undo schedule step IDX-1: recover the previous key and the dropped l word
		prev_rk = spk_pkg::rotl(up_data.rk ^ up_data.l2, 21);
		if (IDX > 0) begin
			nxt.rk = prev_rk;
			nxt.l0 = spk_pkg::rotl((up_data.l2 ^ spk_pkg::word_t'(IDX - 1)) - prev_rk, 8);
			nxt.l1 = up_data.l0;
			nxt.l2 = up_data.l1;
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule
`default_nettype wire

// ----- rtl/speck48_96_cipher.sv -----
// Top level: Speck48/96 encrypt/decrypt as a chain of 46 round cells.
// Latency: every block passes through all 46 cell registers, for both commands.
// Throughput: one block per cycle while out_ready is high; each cell does at most one round and one schedule step.
// 23 forward cells expand the key and encrypt, 23 reverse cells decrypt and unwind the key.
// Stalls pass back combinationally through the ready chain, so bubbles close up under back-pressure.
// Reset clears only the per-cell valid flags; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module speck48_96_cipher (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  command,
	input  wire [23:0]           key_word_0,
	input  wire [23:0]           key_word_1,
	input  wire [23:0]           key_word_2,
	input  wire [23:0]           key_word_3,
	input  wire [23:0]           block_x,
	input  wire [23:0]           block_y,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [23:0]          out_x,
	output logic [23:0]          out_y
);

	spk_pkg::stage_t data  [0:spk_pkg::Stages];
	logic            valid [0:spk_pkg::Stages];
	logic            ready [0:spk_pkg::Stages];

	assign data[0] = '{
		cmd: command,
		x:   block_x,
		y:   block_y,
		l0:  key_word_2,
		l1:  key_word_1,
		l2:  key_word_0,
		rk:  key_word_3
	};

	assign valid[0] = in_valid;
	assign in_ready = ready[0];
	assign ready[spk_pkg::Stages] = out_ready;

	genvar s;
	generate
		for (s = 0; s < spk_pkg::Stages; s++) begin : g_cell
			if (s < spk_pkg::Rounds) begin : g_fwd
				spk_fwd_cell #(.IDX(s)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.up_valid (valid[s]),
					.up_data  (data[s]),
					.up_ready (ready[s]),
					.dn_valid (valid[s+1]),
					.dn_data  (data[s+1]),
					.dn_ready (ready[s+1])
				);
			end else begin : g_rev
				spk_rev_cell #(.IDX(spk_pkg::Stages - 1 - s)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.up_valid (valid[s]),
					.up_data  (data[s]),
					.up_ready (ready[s]),
					.dn_valid (valid[s+1]),
					.dn_data  (data[s+1]),
					.dn_ready (ready[s+1])
				);
			end
		end
	endgenerate

	assign out_valid = valid[spk_pkg::Stages];
	assign out_x     = data[spk_pkg::Stages].x;
	assign out_y     = data[spk_pkg::Stages].y;

endmodule
`default_nettype wire
